>>> design/bracket_pair_matcher_macros.svh
// Assertion macros shared by bpm_outbuf and bracket_pair_matcher.
// Each macro takes a label, the clock, the active-low reset and the terms.
`ifndef BRACKET_PAIR_MATCHER_MACROS_SVH
`define BRACKET_PAIR_MATCHER_MACROS_SVH

`ifndef SYNTH
`define BPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bracket_pair_matcher: same-cycle check failed");
`define BPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bracket_pair_matcher: next-cycle check failed");
`else
`define BPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define BPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> design/bpm_pkg.sv
`default_nettype none

package bpm_pkg;

    localparam int POS_W    = 10;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int CLASS_W  = 3;

    // token classes
    localparam logic [CLASS_W-1:0] CLS_OTHER         = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_OPEN_PAREN    = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_CLOSE_PAREN   = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_OPEN_BRACKET  = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_CLOSE_BRACKET = 3'd4;
    localparam logic [CLASS_W-1:0] CLS_OPEN_BRACE    = 3'd5;
    localparam logic [CLASS_W-1:0] CLS_CLOSE_BRACE   = 3'd6;

    // opener kinds held on the stack
    localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAREN   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BRACKET = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BRACE   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NONE        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MATCHED     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_BRACKET = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_PAREN   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_BRACE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
    } t_entry;

    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    distance;
        logic [POS_W-1:0]    opener_position;
        logic [POS_W-1:0]    token_position;
        logic                statement_end;
    } t_result;

endpackage

`default_nettype wire

>>> design/bpm_cell.sv
`default_nettype none

module bpm_cell (
    input  wire              i_clk,
    input  wire bpm_pkg::t_shift i_shift,
    input  wire bpm_pkg::t_entry i_from_up,
    input  wire bpm_pkg::t_entry i_from_down,
    output bpm_pkg::t_entry  o_entry
);
    import bpm_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // push moves entries away from the top, pop pulls them toward it
    always_comb begin
        priority if (i_shift.push) begin
            n_entry = i_from_up;
        end else if (i_shift.pop) begin
            n_entry = i_from_down;
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

>>> design/bpm_outbuf.sv
`default_nettype none

`include "bracket_pair_matcher_macros.svh"

module bpm_outbuf (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  wire bpm_pkg::t_result i_result,
    output logic              o_can_take,
    output logic              o_valid,
    input  wire               i_ready,
    output bpm_pkg::t_result  o_result
);
    import bpm_pkg::*;

    t_result r_main;
    t_result r_skid;
    logic    r_main_vld;
    logic    r_skid_vld;
    t_result n_main;
    t_result n_skid;
    logic    n_main_vld;
    logic    n_skid_vld;
    logic    pop;

    assign pop        = r_main_vld && i_ready;
    assign o_can_take = !r_skid_vld;
    assign o_valid    = r_main_vld;
    assign o_result   = r_main;

    always_comb begin
        n_main     = r_main;
        n_skid     = r_skid;
        n_main_vld = r_main_vld;
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            if (pop) begin
                n_main     = r_skid;
                n_skid_vld = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_vld || pop) begin
                n_main     = i_result;
                n_main_vld = 1'b1;
            end else begin
                n_skid     = i_result;
                n_skid_vld = 1'b1;
            end
        end else if (pop) begin
            n_main_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_main_vld <= n_main_vld;
            r_skid_vld <= n_skid_vld;
        end
        r_main <= n_main;
        r_skid <= n_skid;
    end

    `BPM_ASSERT_SAME(a_skid_needs_main, i_clk, i_rst_n, r_skid_vld, r_main_vld)
    `BPM_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n,
        i_push && r_main_vld && !i_ready, r_skid_vld)
    `BPM_ASSERT_NEXT(a_skid_moves_up, i_clk, i_rst_n,
        r_skid_vld && i_ready, r_main == $past(r_skid) && r_main_vld)

endmodule

`default_nettype wire

>>> design/bracket_pair_matcher.sv
// bracket_pair_matcher: bracket matching over the tokens of one statement.
// Input channel (i_valid / o_ready) takes one token per item: its bracket
// class, the plain-bracket flag and the end-of-statement mark. Output channel
// (o_valid / i_ready) returns exactly one result item per token: status,
// matched distance and opener position, token position and statement end.
// A token's result is registered in the output buffer; throughput is one
// token per cycle while i_ready stays high. The opener stack is a row of
// STACK_DEPTH shift cells with the top at cell 0, so a push or pop is one
// shift of the whole row and the next token sees the updated top at once.
// The output side has a main register and a skid register; o_ready stays
// high until the skid register fills, i.e. the block takes one more token
// after the receiver stalls and then holds o_ready low until i_ready returns.
// Reset empties the stack, clears the token index and the latched error and
// drops both output registers; the cell contents are left as they are.
// A token flagged as last returns all statement state to zero after its
// result is formed.
`default_nettype none

`include "bracket_pair_matcher_macros.svh"

module bracket_pair_matcher #(
    parameter int STACK_DEPTH = 64,
    parameter int MAX_TOKENS  = 1024
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire  [2:0] i_token_class,
    input  wire        i_plain_bracket,
    input  wire        i_last_token,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [2:0] o_status,
    output logic [9:0] o_distance,
    output logic [9:0] o_opener_position,
    output logic [9:0] o_token_position,
    output logic       o_statement_end
);
    import bpm_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_TOKENS + 1);

    logic [CNT_W-1:0]    r_count;
    logic [IDX_W-1:0]    r_tok_idx;
    logic                r_error;
    logic [CNT_W-1:0]    n_count;
    logic [IDX_W-1:0]    n_tok_idx;
    logic                n_error;

    logic                acc;
    logic                can_take;
    logic [KIND_W-1:0]   open_kind;
    logic [KIND_W-1:0]   close_kind;
    logic [STATUS_W-1:0] bad_code;
    logic [IDX_W+POS_W-1:0] pos_ext;
    logic [POS_W-1:0]    pos;
    logic                too_long;
    logic                full;
    t_entry              top;
    t_entry              new_entry;
    t_shift              shift;
    t_result             res;
    t_result             out_res;

    t_entry              cell_q  [STACK_DEPTH];
    t_entry              cell_up [STACK_DEPTH];
    t_entry              cell_dn [STACK_DEPTH];

    assign acc      = i_valid && o_ready;
    assign o_ready  = can_take;
    assign pos_ext  = {{POS_W{1'b0}}, r_tok_idx};
    assign pos      = pos_ext[POS_W-1:0];
    assign too_long = (r_tok_idx == IDX_W'(MAX_TOKENS));
    assign full     = (r_count == CNT_W'(STACK_DEPTH));
    assign top      = cell_q[0];

    always_comb begin
        open_kind  = KIND_NONE;
        close_kind = KIND_NONE;
        bad_code   = ST_NONE;
        unique case (i_token_class)
            CLS_OPEN_PAREN:    open_kind = KIND_PAREN;
            CLS_OPEN_BRACKET:  open_kind = i_plain_bracket ? KIND_BRACKET : KIND_NONE;
            CLS_OPEN_BRACE:    open_kind = KIND_BRACE;
            CLS_CLOSE_PAREN: begin
                close_kind = KIND_PAREN;
                bad_code   = ST_BAD_PAREN;
            end
            CLS_CLOSE_BRACKET: begin
                close_kind = KIND_BRACKET;
                bad_code   = ST_BAD_BRACKET;
            end
            CLS_CLOSE_BRACE: begin
                close_kind = KIND_BRACE;
                bad_code   = ST_BAD_BRACE;
            end
            default: ;
        endcase
    end

    always_comb begin
        res                 = '0;
        res.token_position  = pos;
        res.statement_end   = i_last_token;
        shift               = '0;
        n_count             = r_count;
        n_error             = r_error;
        new_entry.kind      = open_kind;
        new_entry.pos       = pos;
        if (!r_error && (open_kind != KIND_NONE || close_kind != KIND_NONE)) begin
            priority if (too_long) begin
                res.status = ST_OVERFLOW;
                n_error    = 1'b1;
            end else if (open_kind != KIND_NONE) begin
                if (full) begin
                    res.status = ST_OVERFLOW;
                    n_error    = 1'b1;
                end else begin
                    res.status = ST_STORED;
                    shift.push = 1'b1;
                    n_count    = r_count + 1'b1;
                end
            end else if (r_count == '0) begin
                res.status = bad_code;
                n_error    = 1'b1;
            end else begin
                // pop the top whether it matches or not
                shift.pop = 1'b1;
                n_count   = r_count - 1'b1;
                if (top.kind != close_kind) begin
                    res.status = bad_code;
                    n_error    = 1'b1;
                end else begin
                    res.status          = ST_MATCHED;
                    res.opener_position = top.pos;
                    res.distance        = pos - top.pos;
                end
            end
        end
        n_tok_idx = too_long ? r_tok_idx : r_tok_idx + 1'b1;
        if (i_last_token) begin
            n_count   = '0;
            n_error   = 1'b0;
            n_tok_idx = '0;
        end
        if (!acc) begin
            shift = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_tok_idx <= '0;
            r_error   <= 1'b0;
        end else if (acc) begin
            r_count   <= n_count;
            r_tok_idx <= n_tok_idx;
            r_error   <= n_error;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_top
                assign cell_up[gi] = new_entry;
            end else begin : g_mid_up
                assign cell_up[gi] = cell_q[gi-1];
            end
            if (gi == STACK_DEPTH - 1) begin : g_bottom
                assign cell_dn[gi] = cell_q[gi];
            end else begin : g_mid_dn
                assign cell_dn[gi] = cell_q[gi+1];
            end
            bpm_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (shift),
                .i_from_up   (cell_up[gi]),
                .i_from_down (cell_dn[gi]),
                .o_entry     (cell_q[gi])
            );
        end
    endgenerate

    bpm_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (acc),
        .i_result   (res),
        .o_can_take (can_take),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_result   (out_res)
    );

    assign o_status          = out_res.status;
    assign o_distance        = out_res.distance;
    assign o_opener_position = out_res.opener_position;
    assign o_token_position  = out_res.token_position;
    assign o_statement_end   = out_res.statement_end;

    `BPM_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    `BPM_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, acc && i_last_token,
        r_count == '0 && r_tok_idx == '0 && !r_error)
    `BPM_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        acc && res.status == ST_STORED && !i_last_token,
        r_count == $past(r_count) + 1'b1 && cell_q[0] == $past(new_entry))
    `BPM_ASSERT_SAME(a_error_freezes, i_clk, i_rst_n, acc && r_error,
        res.status == ST_NONE && shift == '0)

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bpm_pkg::*;

    localparam int STACK_DEPTH   = 64;
    localparam int MAX_TOKENS    = 1024;
    localparam int RANDOM_ITEMS  = 100;
    localparam int CYCLE_LIMIT   = 500000;
    localparam logic [CLASS_W-1:0] CLS_RESERVED = 3'd7;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [CLASS_W-1:0] i_token_class = CLS_OTHER;
    logic               i_plain_bracket = 1'b0;
    logic               i_last_token = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [2:0]         o_status;
    logic [9:0]         o_distance;
    logic [9:0]         o_opener_position;
    logic [9:0]         o_token_position;
    logic               o_statement_end;

    // predictor state
    t_entry             opener_stack [STACK_DEPTH];
    int                 opener_count = 0;
    int                 token_pos = 0;
    bit                 stmt_error = 1'b0;

    t_result            bracket_results [$];
    int                 sent_items = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;
    bit                 tx_idle_en = 1'b1;
    bit                 rx_idle_en = 1'b1;
    t_result            want;
    t_result            got;
    int                 stall;

    bracket_pair_matcher #(
        .STACK_DEPTH(STACK_DEPTH),
        .MAX_TOKENS (MAX_TOKENS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_token_class    (i_token_class),
        .i_plain_bracket  (i_plain_bracket),
        .i_last_token     (i_last_token),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_distance       (o_distance),
        .o_opener_position(o_opener_position),
        .o_token_position (o_token_position),
        .o_statement_end  (o_statement_end)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic t_result match_bracket(input logic [CLASS_W-1:0] cls,
                                              input logic plain, input logic last);
        t_result             r;
        logic [KIND_W-1:0]   open_kind;
        logic [KIND_W-1:0]   close_kind;
        logic [STATUS_W-1:0] bad;
        t_entry              top;
        int                  pos;
        r          = '0;
        pos        = token_pos;
        open_kind  = KIND_NONE;
        close_kind = KIND_NONE;
        bad        = ST_NONE;
        if (!stmt_error) begin
            case (cls)
                CLS_OPEN_PAREN:    open_kind = KIND_PAREN;
                CLS_OPEN_BRACKET:  if (plain) open_kind = KIND_BRACKET;
                CLS_OPEN_BRACE:    open_kind = KIND_BRACE;
                CLS_CLOSE_PAREN: begin
                    close_kind = KIND_PAREN;
                    bad        = ST_BAD_PAREN;
                end
                CLS_CLOSE_BRACKET: begin
                    close_kind = KIND_BRACKET;
                    bad        = ST_BAD_BRACKET;
                end
                CLS_CLOSE_BRACE: begin
                    close_kind = KIND_BRACE;
                    bad        = ST_BAD_BRACE;
                end
                default: ;
            endcase
            if (open_kind != KIND_NONE || close_kind != KIND_NONE) begin
                if (pos >= MAX_TOKENS) begin
                    r.status   = ST_OVERFLOW;
                    stmt_error = 1'b1;
                end else if (open_kind != KIND_NONE) begin
                    if (opener_count >= STACK_DEPTH) begin
                        r.status   = ST_OVERFLOW;
                        stmt_error = 1'b1;
                    end else begin
                        opener_stack[opener_count] = '{kind: open_kind, pos: POS_W'(pos)};
                        opener_count++;
                        r.status = ST_STORED;
                    end
                end else if (opener_count == 0) begin
                    r.status   = bad;
                    stmt_error = 1'b1;
                end else begin
                    // pop even on a kind mismatch
                    opener_count--;
                    top = opener_stack[opener_count];
                    if (top.kind != close_kind) begin
                        r.status   = bad;
                        stmt_error = 1'b1;
                    end else begin
                        r.status          = ST_MATCHED;
                        r.opener_position = top.pos;
                        r.distance        = POS_W'(pos) - top.pos;
                    end
                end
            end
        end
        r.token_position = POS_W'(pos);
        r.statement_end  = last;
        if (last) begin
            opener_count = 0;
            token_pos    = 0;
            stmt_error   = 1'b0;
        end else if (token_pos < MAX_TOKENS) begin
            token_pos++;
        end
        return r;
    endfunction

    function automatic logic [CLASS_W-1:0] opener_of(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_PAREN:   return CLS_OPEN_PAREN;
            KIND_BRACKET: return CLS_OPEN_BRACKET;
            default:      return CLS_OPEN_BRACE;
        endcase
    endfunction

    function automatic logic [CLASS_W-1:0] closer_of(input logic [KIND_W-1:0] kind);
        case (kind)
            KIND_PAREN:   return CLS_CLOSE_PAREN;
            KIND_BRACKET: return CLS_CLOSE_BRACKET;
            default:      return CLS_CLOSE_BRACE;
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] any_kind();
        return KIND_W'($urandom_range(KIND_PAREN, KIND_BRACE));
    endfunction

    task automatic send_token(input logic [CLASS_W-1:0] cls, input logic plain,
                              input logic last);
        int      gap;
        t_result r;
        gap = tx_idle_en ? $urandom_range(0, 3) : 0;
        if ($urandom_range(0, 39) == 0) tx_idle_en = !tx_idle_en;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_token_class   <= cls;
        i_plain_bracket <= plain;
        i_last_token    <= last;
        r = match_bracket(cls, plain, last);
        bracket_results.push_back(r);
        sent_items++;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    // tokens that never touch the stack
    task automatic pick_filler(output logic [CLASS_W-1:0] cls, output logic plain);
        plain = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
            0: cls = CLS_OTHER;
            1: cls = CLS_RESERVED;
            default: begin
                cls   = CLS_OPEN_BRACKET;
                plain = 1'b0;
            end
        endcase
    endtask

    task automatic test_directed();
        // nested match with ignored tokens inside
        send_token(CLS_OPEN_PAREN,    1'b0, 1'b0);
        send_token(CLS_OPEN_BRACKET,  1'b1, 1'b0);
        send_token(CLS_OTHER,         1'b1, 1'b0);
        send_token(CLS_RESERVED,      1'b0, 1'b0);
        send_token(CLS_OPEN_BRACKET,  1'b0, 1'b0);
        send_token(CLS_CLOSE_BRACKET, 1'b1, 1'b0);
        send_token(CLS_OPEN_BRACE,    1'b1, 1'b0);
        send_token(CLS_CLOSE_BRACE,   1'b0, 1'b0);
        send_token(CLS_CLOSE_PAREN,   1'b1, 1'b1);
        // wrong kind, then the error holds to the end of the statement
        send_token(CLS_OPEN_PAREN,    1'b0, 1'b0);
        send_token(CLS_CLOSE_BRACKET, 1'b0, 1'b0);
        send_token(CLS_CLOSE_PAREN,   1'b0, 1'b0);
        send_token(CLS_OPEN_BRACE,    1'b0, 1'b1);
        // closers on an empty stack, then a closer of the wrong kind
        send_token(CLS_CLOSE_PAREN,   1'b0, 1'b1);
        send_token(CLS_CLOSE_BRACE,   1'b1, 1'b1);
        send_token(CLS_CLOSE_BRACKET, 1'b0, 1'b1);
        send_token(CLS_OPEN_BRACKET,  1'b1, 1'b0);
        send_token(CLS_CLOSE_BRACE,   1'b0, 1'b0);
        send_token(CLS_OPEN_PAREN,    1'b1, 1'b1);
        // openers left at the end are dropped silently
        send_token(CLS_OPEN_BRACE,    1'b0, 1'b0);
        send_token(CLS_OPEN_PAREN,    1'b0, 1'b0);
        send_token(CLS_OPEN_BRACKET,  1'b1, 1'b1);
        send_token(CLS_CLOSE_PAREN,   1'b0, 1'b1);
    endtask

    task automatic test_full_stack();
        logic [KIND_W-1:0] kinds [STACK_DEPTH];
        for (int i = 0; i < STACK_DEPTH; i++) begin
            kinds[i] = any_kind();
            send_token(opener_of(kinds[i]), 1'b1, 1'b0);
        end
        send_token(CLS_OPEN_PAREN, 1'b1, 1'b0);
        send_token(CLS_CLOSE_PAREN, 1'b0, 1'b0);
        send_token(CLS_OTHER, 1'b0, 1'b1);
        // fill to the top, then unwind every level
        for (int i = 0; i < STACK_DEPTH; i++) begin
            kinds[i] = any_kind();
            send_token(opener_of(kinds[i]), 1'b1, 1'b0);
        end
        for (int i = STACK_DEPTH - 1; i >= 0; i--)
            send_token(closer_of(kinds[i]), 1'($urandom_range(0, 1)), i == 0);
    endtask

    task automatic test_long_statement();
        logic [CLASS_W-1:0] cls;
        logic               plain;
        send_token(CLS_OPEN_PAREN, 1'b1, 1'b0);
        for (int p = 1; p < MAX_TOKENS - 1; p++) begin
            pick_filler(cls, plain);
            send_token(cls, plain, 1'b0);
        end
        send_token(CLS_CLOSE_PAREN, 1'b0, 1'b0);
        // past the limit: the index saturates and the next bracket overflows
        send_token(CLS_CLOSE_BRACE, 1'b1, 1'b0);
        send_token(CLS_OPEN_PAREN, 1'b1, 1'b0);
        pick_filler(cls, plain);
        send_token(cls, plain, 1'b0);
        send_token(CLS_OTHER, 1'b0, 1'b1);
    endtask

    task automatic run_statement(input bit broken);
        logic [KIND_W-1:0]  kinds [$];
        logic [KIND_W-1:0]  kind;
        logic [CLASS_W-1:0] cls;
        logic               plain;
        int                 len;
        int                 cap;
        int                 left;
        int                 pick;
        int                 flip_at;
        bit                 close_all;
        bit                 corrupt;
        len       = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 140)
                                                : $urandom_range(1, 24);
        cap       = (len > 40) ? STACK_DEPTH : $urandom_range(1, 8);
        close_all = $urandom_range(0, 3) != 0;
        corrupt   = $urandom_range(0, 4) == 0;
        flip_at   = $urandom_range(0, len - 1);
        for (int k = 0; k < len; k++) begin
            left = len - k;
            pick = $urandom_range(0, 9);
            plain = 1'($urandom_range(0, 1));
            if (broken) begin
                cls = CLASS_W'($urandom_range(0, 7));
            end else if (close_all && kinds.size() >= left - 1 && kinds.size() == 0) begin
                pick_filler(cls, plain);
            end else if ((close_all && kinds.size() >= left - 1) ||
                         (pick >= 6 && kinds.size() > 0) ||
                         (pick >= 2 && kinds.size() >= cap)) begin
                kind = kinds.pop_back();
                if (corrupt && k >= flip_at) begin
                    kind    = (kind == KIND_BRACE) ? KIND_PAREN : KIND_W'(kind + 1);
                    corrupt = 1'b0;
                end
                cls = closer_of(kind);
            end else if (pick >= 2) begin
                kind = any_kind();
                kinds.push_back(kind);
                cls = opener_of(kind);
                if (kind == KIND_BRACKET) plain = 1'b1;
            end else begin
                pick_filler(cls, plain);
            end
            send_token(cls, plain, k == len - 1);
        end
    endtask

    task automatic test_random_statements();
        int start;
        start = sent_items;
        while (sent_items - start < RANDOM_ITEMS)
            run_statement($urandom_range(0, 4) == 0);
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        forever begin
            stall = rx_idle_en ? $urandom_range(0, 3) : 0;
            if ($urandom_range(0, 39) == 0) rx_idle_en = !rx_idle_en;
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = '{o_status, o_distance, o_opener_position, o_token_position,
                    o_statement_end};
            if (bracket_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d pos %0d", o_status,
                             o_token_position);
            end else begin
                want = bracket_results.pop_front();
                if (got.status !== want.status || got.distance !== want.distance ||
                    got.opener_position !== want.opener_position ||
                    got.token_position !== want.token_position ||
                    got.statement_end !== want.statement_end) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: status %0d/%0d distance %0d/%0d ",
                                  "opener %0d/%0d pos %0d/%0d end %0d/%0d (exp/got)"},
                                 want.status, got.status, want.distance, got.distance,
                                 want.opener_position, got.opener_position,
                                 want.token_position, got.token_position,
                                 want.statement_end, got.statement_end);
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_stack();
        test_long_statement();
        test_random_statements();
        i_valid <= 1'b0;
        while (bracket_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        if (mismatches == 0 && bracket_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/bpm_pkg.sv
design/bpm_cell.sv
design/bpm_outbuf.sv
design/bracket_pair_matcher.sv
test/tb_top.sv
